// ----- rtl/lpss_pkg.sv -----
// Shared types, codes and helpers of the length-prefixed stream serializer.
// No dependencies; every other file of the block imports this package.
package lpss_pkg;

  localparam int LPSS_QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    CMD_VALUE   = 3'd0,
    CMD_BLOCK   = 3'd1,
    CMD_DATA    = 3'd2,
    CMD_SIZED   = 3'd3,
    CMD_UNSIZED = 3'd4,
    CMD_CHUNK   = 3'd5,
    CMD_END     = 3'd6
  } lpss_cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_STATE     = 2'd1,
    ERR_TOO_LARGE = 2'd2,
    ERR_MISMATCH  = 2'd3
  } lpss_err_t;

  typedef enum logic [1:0] {
    ORD_BIG    = 2'd0,
    ORD_LITTLE = 2'd1
  } lpss_ord_t;

  typedef enum logic [1:0] {
    SZ_ONE   = 2'd0,
    SZ_TWO   = 2'd1,
    SZ_FOUR  = 2'd2,
    SZ_EIGHT = 2'd3
  } lpss_size_t;

  localparam logic [0:0] REG_NATIVE_ORDER = 1'b0;

  // One entry of the job queue: the bytes already in emit order, the index
  // of the final byte, and an error code (an error job emits one result).
  typedef struct packed {
    logic [63:0] bytes;
    logic [2:0]  last_idx;
    logic [1:0]  err;
  } lpss_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lpss_qstat_t;

  // Index of the final byte for a width code of 1, 2, 4 or 8 bytes.
  function automatic logic [2:0] size_last_idx(input logic [1:0] code);
    logic [2:0] r;
    case (code)
      SZ_ONE:  r = 3'd0;
      SZ_TWO:  r = 3'd1;
      SZ_FOUR: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // Length prefixes are 1, 2 or 4 bytes; code three falls back to four.
  function automatic logic [1:0] prefix_to_size(input logic [1:0] pcode);
    logic [1:0] r;
    case (pcode)
      SZ_ONE:  r = SZ_ONE;
      SZ_TWO:  r = SZ_TWO;
      default: r = SZ_FOUR;
    endcase
    return r;
  endfunction

  function automatic logic too_large(input logic [31:0] len, input logic [1:0] pcode);
    logic r;
    case (pcode)
      SZ_ONE:  r = (len[31:8] != '0);
      SZ_TWO:  r = (len[31:16] != '0);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Places the low bytes of v in emit order: slot i holds the i-th byte out.
  function automatic logic [63:0] order_bytes(input logic [63:0] v,
                                              input logic [2:0] last_idx,
                                              input logic big);
    logic [63:0] r;
    logic [2:0]  src;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      src = big ? (last_idx - 3'(i)) : 3'(i);
      r[8*i +: 8] = v[8*src +: 8];
    end
    return r;
  endfunction

endpackage

// ----- rtl/lpss_in_if.sv -----
// Command channel of the serializer: valid/ready handshake plus one command.
// Depends on lpss_pkg.
interface lpss_in_if import lpss_pkg::*;;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] value;
  logic [1:0]  value_size;
  logic [1:0]  byte_order;
  logic [31:0] length;
  logic [1:0]  prefix_size;
  logic [7:0]  data_byte;

  modport source (output valid, command, value, value_size, byte_order, length,
                  prefix_size, data_byte, input ready);
  modport sink (input valid, command, value, value_size, byte_order, length,
                prefix_size, data_byte, output ready);
endinterface

// ----- rtl/lpss_out_if.sv -----
// Result channel of the serializer: valid/ready handshake plus one result beat.
// Depends on lpss_pkg.
interface lpss_out_if import lpss_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic [1:0] error;
  logic       last;

  modport source (output valid, out_byte, has_byte, error, last, input ready);
  modport sink (input valid, out_byte, has_byte, error, last, output ready);
endinterface

// ----- rtl/lpss_front.sv -----
// Front end: accepts commands, tracks stream mode and byte counts, and turns
// each command into at most one job for the queue. Depends on lpss_pkg.
module lpss_front import lpss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lpss_in_if.sink     in_bus,
  input  logic        native_big,
  input  lpss_qstat_t qstat,
  output logic        push,
  output lpss_job_t   push_job
);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_BLOCK, MODE_SIZED, MODE_UNSIZED, MODE_CHUNK
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  spc_r, spc_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        accept;
  logic        big;
  logic [31:0] rem_dec;

  assign in_bus.ready = !qstat.full;
  assign accept = in_bus.valid && in_bus.ready;
  assign rem_dec = rem_r - 32'd1;

  always_comb begin
    case (in_bus.byte_order)
      ORD_BIG:    big = 1'b1;
      ORD_LITTLE: big = 1'b0;
      default:    big = native_big;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    spc_nxt  = spc_r;
    rem_nxt  = rem_r;
    push     = 1'b0;
    push_job = '{bytes: '0, last_idx: 3'd0, err: ERR_NONE};

    if (accept) begin
      case (in_bus.command)
        CMD_VALUE: begin
          push = 1'b1;
          if (mode_r != MODE_IDLE) begin
            push_job.err = ERR_STATE;
          end else begin
            push_job.last_idx = size_last_idx(in_bus.value_size);
            push_job.bytes = order_bytes(in_bus.value, push_job.last_idx, big);
          end
        end
        CMD_BLOCK: begin
          if (mode_r != MODE_IDLE) begin
            push = 1'b1;
            push_job.err = ERR_STATE;
          end else if (in_bus.length != '0) begin
            push = 1'b1;
            if (too_large(in_bus.length, in_bus.prefix_size)) begin
              push_job.err = ERR_TOO_LARGE;
            end else begin
              mode_nxt = MODE_BLOCK;
              rem_nxt  = in_bus.length;
              push_job.last_idx = size_last_idx(prefix_to_size(in_bus.prefix_size));
              push_job.bytes = order_bytes({32'd0, in_bus.length},
                                           push_job.last_idx, 1'b1);
            end
          end
        end
        CMD_DATA: begin
          push = 1'b1;
          push_job.bytes = {56'd0, in_bus.data_byte};
          if (mode_r == MODE_SIZED) begin
            if (rem_r == '0) begin
              push_job.bytes = '0;
              push_job.err = ERR_MISMATCH;
            end else begin
              rem_nxt = rem_dec;
            end
          end else if (mode_r == MODE_BLOCK || mode_r == MODE_CHUNK) begin
            rem_nxt = rem_dec;
            if (rem_dec == '0) begin
              mode_nxt = (mode_r == MODE_BLOCK) ? MODE_IDLE : MODE_UNSIZED;
            end
          end else begin
            push_job.bytes = '0;
            push_job.err = ERR_STATE;
          end
        end
        CMD_SIZED: begin
          push = 1'b1;
          if (mode_r != MODE_IDLE) begin
            push_job.err = ERR_STATE;
          end else if (too_large(in_bus.length, in_bus.prefix_size)) begin
            push_job.err = ERR_TOO_LARGE;
          end else begin
            mode_nxt = MODE_SIZED;
            rem_nxt  = in_bus.length;
            push_job.last_idx = size_last_idx(prefix_to_size(in_bus.prefix_size));
            push_job.bytes = order_bytes({32'd0, in_bus.length},
                                         push_job.last_idx, 1'b1);
          end
        end
        CMD_UNSIZED: begin
          if (mode_r != MODE_IDLE) begin
            push = 1'b1;
            push_job.err = ERR_STATE;
          end else begin
            mode_nxt = MODE_UNSIZED;
            spc_nxt  = in_bus.prefix_size;
          end
        end
        CMD_CHUNK: begin
          // Inside a sized stream a chunk only checks against the remaining count.
          if (mode_r == MODE_SIZED) begin
            if (in_bus.length > rem_r) begin
              push = 1'b1;
              push_job.err = ERR_MISMATCH;
            end
          end else if (mode_r != MODE_UNSIZED) begin
            push = 1'b1;
            push_job.err = ERR_STATE;
          end else if (in_bus.length != '0) begin
            push = 1'b1;
            if (too_large(in_bus.length, spc_r)) begin
              push_job.err = ERR_TOO_LARGE;
            end else begin
              mode_nxt = MODE_CHUNK;
              rem_nxt  = in_bus.length;
              push_job.last_idx = size_last_idx(prefix_to_size(spc_r));
              push_job.bytes = order_bytes({32'd0, in_bus.length},
                                           push_job.last_idx, 1'b1);
            end
          end
        end
        CMD_END: begin
          if (mode_r == MODE_SIZED) begin
            if (rem_r != '0) begin
              push = 1'b1;
              push_job.err = ERR_MISMATCH;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end else if (mode_r != MODE_UNSIZED) begin
            push = 1'b1;
            push_job.err = ERR_STATE;
          end else begin
            // The terminating zero prefix is all zero bytes.
            push = 1'b1;
            mode_nxt = MODE_IDLE;
            push_job.last_idx = size_last_idx(prefix_to_size(spc_r));
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      spc_r  <= 2'd0;
      rem_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      spc_r  <= spc_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

// ----- rtl/lpss_queue.sv -----
// Small job queue between the command front end and the byte serializer.
// Depends on lpss_pkg.
module lpss_queue import lpss_pkg::*; #(
  parameter int DEPTH = LPSS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lpss_job_t   push_job,
  input  logic        pop,
  output lpss_job_t   head,
  output lpss_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpss_job_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign qstat.full  = (count_r == CNT_W'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full)) else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qstat.empty)) else $error("job popped from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ----- rtl/lpss_back.sv -----
// Back end: walks the job at the queue head one byte per beat into a
// registered output stage. Depends on lpss_pkg.
module lpss_back import lpss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lpss_job_t   head,
  input  lpss_qstat_t qstat,
  output logic        pop,
  lpss_out_if.source  out_bus
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       has_r, has_nxt;
  logic [1:0] err_r, err_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       at_last;

  assign load    = !qstat.empty && (!valid_r || out_bus.ready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    has_nxt   = has_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = head.bytes[8*idx_r +: 8];
      has_nxt   = (head.err == ERR_NONE);
      err_nxt   = head.err;
      last_nxt  = at_last;
      idx_nxt   = at_last ? 3'd0 : idx_r + 3'd1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
    has_r  <= has_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

  assign out_bus.valid    = valid_r;
  assign out_bus.out_byte = byte_r;
  assign out_bus.has_byte = has_r;
  assign out_bus.error    = err_r;
  assign out_bus.last     = last_r;

`ifndef SYNTH
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !has_r) |-> (last_r && err_r != ERR_NONE && byte_r == 8'd0))
    else $error("error beat is not a lone final beat");
  a_byte_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && has_r) |-> (err_r == ERR_NONE))
    else $error("data beat carries an error code");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !qstat.empty |-> (idx_r <= head.last_idx))
    else $error("byte index ran past the job");
`endif

endmodule

// ----- rtl/length_prefixed_stream_serializer_unit.sv -----
// Top level of the length-prefixed stream serializer: APB register, front
// end, job queue and byte serializer. Depends on lpss_pkg and the channel interfaces.
//
// Commands are accepted one per cycle whenever the job queue has room; each
// command is decoded in the cycle it is taken and leaves at most one job.
// Results leave one beat per cycle while the result side is ready; a command
// emits 1 beat for a data byte or an error, 1 to 4 for a length prefix, up
// to 8 for a value write, and none for commands that emit nothing.
// The output serializer sets the sustained rate; the queue (QUEUE_DEPTH jobs)
// lets single-byte traffic run at one item per cycle while longer writes drain,
// until the queue fills. With the queue empty, the first result of a command
// passes the queue entry and then the registered output stage before it is valid.
// Register native_big_endian lies at byte address 0; write it only while idle.
module length_prefixed_stream_serializer_unit import lpss_pkg::*; #(
  parameter int QUEUE_DEPTH = LPSS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  lpss_in_if.sink     in_bus,
  lpss_out_if.source  out_bus,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        native_big_r;
  logic        push;
  lpss_job_t   push_job;
  logic        pop;
  lpss_job_t   head;
  lpss_qstat_t qstat;
  logic        reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == REG_NATIVE_ORDER);
  assign cfg_prdata = reg_hit ? {31'd0, native_big_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      native_big_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      native_big_r <= cfg_pwdata[0];
    end
  end

  lpss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .native_big (native_big_r),
    .qstat      (qstat),
    .push       (push),
    .push_job   (push_job)
  );

  lpss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  lpss_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for length_prefixed_stream_serializer_unit: directed and random
// command traffic, an in-bench model of the framing state, and beat-by-beat result checks.
// Depends on lpss_pkg and the lpss_in_if / lpss_out_if channel interfaces.
module testbench;
  import lpss_pkg::*;

  localparam logic [2:0] CMD_RESERVED      = 3'd7;
  localparam logic [1:0] ORD_NATIVE        = 2'd2;
  localparam logic [1:0] ORD_NATIVE_ALT    = 2'd3;
  localparam logic [2:0] NATIVE_ORDER_ADDR = {REG_NATIVE_ORDER, 2'b00};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLOCK,
    ST_SIZED,
    ST_UNSIZED,
    ST_CHUNK
  } frame_state_t;

  typedef struct {
    logic [2:0]  command;
    logic [63:0] value;
    logic [1:0]  value_size;
    logic [1:0]  byte_order;
    logic [31:0] length;
    logic [1:0]  prefix_size;
    logic [7:0]  data_byte;
  } ser_cmd_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] error;
    logic       last;
  } ser_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lpss_in_if  in_bus();
  lpss_out_if out_bus();

  length_prefixed_stream_serializer_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Framing state as the block should hold it, updated at each accepted command.
  frame_state_t mode = ST_IDLE;
  logic [1:0]   stream_pcode = '0;
  logic [31:0]  remaining = '0;
  bit           native_big = 1'b0;

  ser_beat_t expected_beats[$];
  int        failures = 0;
  int        items_sent = 0;
  bit        steady = 1'b0;
  int        result_hold = 0;

  always #6 clk = ~clk;

  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int prefix_len(logic [1:0] code);
    if (code == SZ_ONE) return 1;
    if (code == SZ_TWO) return 2;
    return 4;
  endfunction

  function automatic bit len_exceeds(logic [31:0] len, logic [1:0] code);
    if (code == SZ_ONE) return len > 32'd255;
    if (code == SZ_TWO) return len > 32'd65535;
    return 1'b0;
  endfunction

  function automatic void push_bytes(logic [63:0] v, int n, bit msb_first);
    ser_beat_t b;
    int idx;
    for (int i = 0; i < n; i++) begin
      idx = msb_first ? n - 1 - i : i;
      b.out_byte = v[8*idx +: 8];
      b.has_byte = 1'b1;
      b.error    = ERR_NONE;
      b.last     = (i == n - 1);
      expected_beats.push_back(b);
    end
  endfunction

  function automatic void push_error(lpss_err_t e);
    ser_beat_t b;
    b.out_byte = '0;
    b.has_byte = 1'b0;
    b.error    = e;
    b.last     = 1'b1;
    expected_beats.push_back(b);
  endfunction

  // Applies one accepted command to the framing state and queues its beats.
  function automatic void track_command(ser_cmd_t c);
    bit msb_first;
    case (c.command)
      CMD_VALUE: begin
        if (mode != ST_IDLE) begin
          push_error(ERR_STATE);
        end else begin
          msb_first = (c.byte_order == ORD_BIG) ? 1'b1 :
                      (c.byte_order == ORD_LITTLE) ? 1'b0 : native_big;
          push_bytes(c.value, 1 << c.value_size, msb_first);
        end
      end
      CMD_BLOCK: begin
        if (mode != ST_IDLE) begin
          push_error(ERR_STATE);
        end else if (c.length == 0) begin
        end else if (len_exceeds(c.length, c.prefix_size)) begin
          push_error(ERR_TOO_LARGE);
        end else begin
          mode = ST_BLOCK;
          remaining = c.length;
          push_bytes({32'b0, c.length}, prefix_len(c.prefix_size), 1'b1);
        end
      end
      CMD_DATA: begin
        if (mode == ST_SIZED) begin
          if (remaining == 0) begin
            push_error(ERR_MISMATCH);
          end else begin
            remaining--;
            push_bytes({56'b0, c.data_byte}, 1, 1'b1);
          end
        end else if (mode == ST_BLOCK || mode == ST_CHUNK) begin
          remaining--;
          if (remaining == 0) mode = (mode == ST_BLOCK) ? ST_IDLE : ST_UNSIZED;
          push_bytes({56'b0, c.data_byte}, 1, 1'b1);
        end else begin
          push_error(ERR_STATE);
        end
      end
      CMD_SIZED: begin
        if (mode != ST_IDLE) begin
          push_error(ERR_STATE);
        end else if (len_exceeds(c.length, c.prefix_size)) begin
          push_error(ERR_TOO_LARGE);
        end else begin
          mode = ST_SIZED;
          remaining = c.length;
          push_bytes({32'b0, c.length}, prefix_len(c.prefix_size), 1'b1);
        end
      end
      CMD_UNSIZED: begin
        if (mode != ST_IDLE) begin
          push_error(ERR_STATE);
        end else begin
          mode = ST_UNSIZED;
          stream_pcode = c.prefix_size;
        end
      end
      CMD_CHUNK: begin
        // Inside a sized stream a chunk only checks against the remaining count.
        if (mode == ST_SIZED) begin
          if (c.length > remaining) push_error(ERR_MISMATCH);
        end else if (mode != ST_UNSIZED) begin
          push_error(ERR_STATE);
        end else if (c.length == 0) begin
        end else if (len_exceeds(c.length, stream_pcode)) begin
          push_error(ERR_TOO_LARGE);
        end else begin
          mode = ST_CHUNK;
          remaining = c.length;
          push_bytes({32'b0, c.length}, prefix_len(stream_pcode), 1'b1);
        end
      end
      CMD_END: begin
        if (mode == ST_SIZED) begin
          if (remaining != 0) push_error(ERR_MISMATCH);
          else mode = ST_IDLE;
        end else if (mode != ST_UNSIZED) begin
          push_error(ERR_STATE);
        end else begin
          mode = ST_IDLE;
          push_bytes('0, prefix_len(stream_pcode), 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic ser_cmd_t make_cmd(logic [2:0] cmd);
    ser_cmd_t c;
    c.command     = cmd;
    c.value       = {$urandom, $urandom};
    c.value_size  = 2'($urandom_range(0, 3));
    c.byte_order  = 2'($urandom_range(0, 3));
    c.length      = $urandom;
    c.prefix_size = 2'($urandom_range(0, 3));
    c.data_byte   = 8'($urandom);
    return c;
  endfunction

  // Mostly short frames; some empty, a few long, and oversize lengths where the
  // prefix width can be exceeded.
  function automatic logic [31:0] pick_length(logic [1:0] code);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12 && code == SZ_ONE) return $urandom | 32'h100;
    if (r < 12 && code == SZ_TWO) return $urandom | 32'h1_0000;
    if (r < 16) return (code == SZ_ONE) ? $urandom_range(200, 255) : $urandom_range(256, 400);
    if (r < 24) return 0;
    return $urandom_range(1, 10);
  endfunction

  task automatic send_item(input ser_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.command     <= c.command;
    in_bus.value       <= c.value;
    in_bus.value_size  <= c.value_size;
    in_bus.byte_order  <= c.byte_order;
    in_bus.length      <= c.length;
    in_bus.prefix_size <= c.prefix_size;
    in_bus.data_byte   <= c.data_byte;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    track_command(c);
    if (c.command != CMD_RESERVED) items_sent++;
  endtask

  task automatic send_value(logic [63:0] v, logic [1:0] sz, logic [1:0] ord);
    ser_cmd_t c;
    c = make_cmd(CMD_VALUE);
    c.value = v;
    c.value_size = sz;
    c.byte_order = ord;
    send_item(c);
  endtask

  task automatic send_frame(logic [2:0] cmd, logic [31:0] len, logic [1:0] pcode);
    ser_cmd_t c;
    c = make_cmd(cmd);
    c.length = len;
    c.prefix_size = pcode;
    send_item(c);
  endtask

  task automatic send_data(logic [7:0] b);
    ser_cmd_t c;
    c = make_cmd(CMD_DATA);
    c.data_byte = b;
    send_item(c);
  endtask

  task automatic send_noise();
    ser_cmd_t c;
    c = make_cmd(3'($urandom_range(0, 7)));
    c.length = pick_length(c.command == CMD_CHUNK ? stream_pcode : c.prefix_size);
    send_item(c);
  endtask

  task automatic fill_payload();
    while (mode == ST_BLOCK || mode == ST_CHUNK) begin
      if ($urandom_range(0, 39) == 0) send_noise();
      else send_data(8'($urandom));
    end
  endtask

  task automatic close_open_frame();
    while (mode != ST_IDLE) begin
      if (mode == ST_UNSIZED || (mode == ST_SIZED && remaining == 0))
        send_frame(CMD_END, $urandom, 2'($urandom_range(0, 3)));
      else
        send_data(8'($urandom));
    end
  endtask

  // Register writes happen only with the command side quiet and all beats back.
  task automatic write_native_order(bit big);
    logic [31:0] wdata;
    in_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    wdata = $urandom;
    wdata[0] = big;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= NATIVE_ORDER_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    native_big = big;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[0] !== big) begin
      $error("native_big_endian: expected %0b, got %0b", big, cfg_prdata[0]);
      failures++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_value_writes();
    send_value('1, SZ_EIGHT, ORD_BIG);
    send_value(64'h0123_4567_89AB_CDEF, SZ_EIGHT, ORD_LITTLE);
    send_value(64'hFFFF_0000_0000_00A5, SZ_ONE, ORD_NATIVE);
    send_value(64'h0000_0000_0000_BEEF, SZ_TWO, ORD_NATIVE_ALT);
  endtask

  task automatic test_blocks();
    send_frame(CMD_BLOCK, 32'd2, SZ_ONE);
    send_data(8'h00);
    send_data(8'hFF);
    send_frame(CMD_BLOCK, 32'd0, SZ_TWO);
    send_frame(CMD_BLOCK, 32'd256, SZ_ONE);
    send_frame(CMD_BLOCK, 32'd65536, SZ_TWO);
  endtask

  task automatic test_wrong_state();
    ser_cmd_t c;
    send_data(8'h5A);
    send_frame(CMD_CHUNK, 32'd1, SZ_ONE);
    send_frame(CMD_END, 32'd0, SZ_ONE);
    c = make_cmd(CMD_RESERVED);
    send_item(c);
  endtask

  task automatic test_sized_stream();
    send_frame(CMD_SIZED, 32'd1, SZ_TWO);
    send_frame(CMD_CHUNK, 32'd2, SZ_ONE);
    send_frame(CMD_CHUNK, 32'd1, SZ_ONE);
    send_frame(CMD_END, 32'd0, SZ_ONE);
    send_data(8'h81);
    // One byte past the announced length must be flagged.
    send_data(8'h7E);
    send_value('1, SZ_ONE, ORD_BIG);
    send_frame(CMD_END, 32'd0, SZ_ONE);
  endtask

  task automatic test_unsized_stream();
    // Prefix code three falls back to a four-byte prefix.
    send_frame(CMD_UNSIZED, 32'd0, SZ_EIGHT);
    send_frame(CMD_CHUNK, 32'd0, SZ_ONE);
    send_frame(CMD_CHUNK, 32'd1, SZ_ONE);
    send_data(8'hC3);
    send_frame(CMD_END, 32'd0, SZ_ONE);
  endtask

  task automatic test_native_order();
    write_native_order(1'b1);
    send_value(64'h1122_3344_5566_7788, SZ_FOUR, ORD_NATIVE);
    send_value(64'h1122_3344_5566_7788, SZ_EIGHT, ORD_NATIVE_ALT);
  endtask

  // The result side holds off while eight-byte writes keep coming, so the job
  // queue fills and the command side must stall.
  task automatic test_backpressure();
    close_open_frame();
    steady = 1'b1;
    result_hold = 300;
    repeat (12) send_value({$urandom, $urandom}, SZ_EIGHT, 2'($urandom_range(0, 3)));
    steady = 1'b0;
  endtask

  task automatic rand_value();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom, $urandom};
    endcase
    send_value(v, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  task automatic rand_block();
    logic [1:0] pcode;
    pcode = 2'($urandom_range(0, 3));
    send_frame(CMD_BLOCK, pick_length(pcode), pcode);
    fill_payload();
  endtask

  task automatic rand_sized();
    logic [1:0] pcode;
    int r;
    pcode = 2'($urandom_range(0, 3));
    send_frame(CMD_SIZED, pick_length(pcode), pcode);
    while (mode == ST_SIZED) begin
      r = $urandom_range(0, 99);
      if (remaining == 0) begin
        if (r < 15) send_data(8'($urandom));
        else if (r < 25) send_noise();
        else send_frame(CMD_END, $urandom, 2'($urandom_range(0, 3)));
      end else begin
        if (r < 15) send_frame(CMD_CHUNK, $urandom_range(0, remaining + 2),
                               2'($urandom_range(0, 3)));
        else if (r < 20) send_frame(CMD_END, $urandom, 2'($urandom_range(0, 3)));
        else if (r < 24) send_noise();
        else send_data(8'($urandom));
      end
    end
  endtask

  task automatic rand_unsized();
    send_frame(CMD_UNSIZED, $urandom, 2'($urandom_range(0, 3)));
    repeat ($urandom_range(0, 3)) begin
      send_frame(CMD_CHUNK, pick_length(stream_pcode), 2'($urandom_range(0, 3)));
      fill_payload();
    end
    if ($urandom_range(0, 19) == 0) send_noise();
    close_open_frame();
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 3; phase++) begin
      write_native_order(phase == 1);
      target = items_sent + 140;
      while (items_sent < target) begin
        steady = ($urandom_range(0, 9) == 0);
        close_open_frame();
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: rand_value();
          7, 8, 9, 10, 11:     rand_block();
          12, 13, 14:          rand_sized();
          15, 16, 17:          rand_unsized();
          default:             send_noise();
        endcase
      end
    end
    steady = 1'b0;
  endtask

  // A sized stream with a full 32-bit length is left open: its payload is far
  // too long to send, but the prefix and the size checks are exercised.
  task automatic test_open_stream();
    close_open_frame();
    send_frame(CMD_SIZED, $urandom | 32'h8000_0000, SZ_FOUR);
    repeat (5) send_data(8'($urandom));
    send_frame(CMD_CHUNK, '1, SZ_ONE);
    send_frame(CMD_CHUNK, 32'd3, SZ_ONE);
    send_frame(CMD_END, 32'd0, SZ_ONE);
  endtask

  initial begin : result_sink
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_hold > 0) begin
        stall = result_hold;
        result_hold = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : beat_check
    ser_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: out_byte %02h has_byte %0b error %0d",
               out_bus.out_byte, out_bus.has_byte, out_bus.error);
        failures++;
      end else begin
        want = expected_beats.pop_front();
        if (out_bus.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_bus.out_byte);
          failures++;
        end
        if (out_bus.has_byte !== want.has_byte) begin
          $error("has_byte: expected %0b, got %0b", want.has_byte, out_bus.has_byte);
          failures++;
        end
        if (out_bus.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, out_bus.error);
          failures++;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_bus.last);
          failures++;
        end
      end
    end
  end

  initial begin : run
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.command     = CMD_VALUE;
    in_bus.value       = '0;
    in_bus.value_size  = SZ_ONE;
    in_bus.byte_order  = ORD_BIG;
    in_bus.length      = '0;
    in_bus.prefix_size = SZ_ONE;
    in_bus.data_byte   = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_native_order(1'b0);
    test_value_writes();
    test_blocks();
    test_wrong_state();
    test_sized_stream();
    test_unsized_stream();
    test_native_order();
    test_backpressure();
    test_random_traffic();
    test_open_stream();
    in_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
